### rtl/rbd_pkg.sv
package rbd_pkg;

  localparam int PIX_W                = 32;
  localparam int CH_W                 = 8;
  localparam int NUM_CH               = 4;
  localparam int PAIR_W               = CH_W + 1;
  localparam int QUAD_W               = CH_W + 2;
  localparam int LINE_W               = NUM_CH * PAIR_W;
  localparam int CFG_W                = 13;
  localparam int CFG_IDX_W            = 1;
  localparam int ROW_W                = 12;
  localparam int HGT_W                = 13;
  localparam int MAX_SOURCE_HEIGHT    = 4096;
  localparam int DEF_MAX_SOURCE_WIDTH = 4096;
  localparam int RST_SOURCE_WIDTH     = 4096;
  localparam int RST_SOURCE_HEIGHT    = 4096;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 1'b1;

  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [LINE_W-1:0] line_t;

  // per-beat decode handed from sequencer to datapath
  typedef struct packed {
    logic hold_left;
    logic line_wr;
    logic line_rd;
    logic emit;
    logic zero;
    logic last;
  } ctl_t;

  function automatic line_t pair_sum(input pix_t left, input pix_t right);
    line_t s;
    s = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      s[c*PAIR_W +: PAIR_W] = PAIR_W'(left[c*CH_W +: CH_W]) + PAIR_W'(right[c*CH_W +: CH_W]);
    end
    return s;
  endfunction

  function automatic pix_t box_avg(input line_t top, input line_t bot);
    pix_t p;
    logic [QUAD_W-1:0] q;
    p = '0;
    q = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      q = QUAD_W'(top[c*PAIR_W +: PAIR_W]) + QUAD_W'(bot[c*PAIR_W +: PAIR_W]);
      p[c*CH_W +: CH_W] = q[QUAD_W-1:2];
    end
    return p;
  endfunction

endpackage

### rtl/rbd_if.sv
interface rbd_src_if import rbd_pkg::*; ();
  logic valid;
  logic ready;
  pix_t source_pixel;

  modport source (output valid, output source_pixel, input ready);
  modport sink   (input valid, input source_pixel, output ready);
endinterface

interface rbd_mip_if import rbd_pkg::*; ();
  logic valid;
  logic ready;
  pix_t mip_pixel;
  logic level_done;

  modport source (output valid, output mip_pixel, output level_done, input ready);
  modport sink   (input valid, input mip_pixel, input level_done, output ready);
endinterface

### rtl/rbd_ram.sv
module rbd_ram import rbd_pkg::*; #(
  parameter int WIDTH = LINE_W,
  parameter int DEPTH = DEF_MAX_SOURCE_WIDTH / 2
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/rbd_seq.sv
module rbd_seq import rbd_pkg::*; #(
  parameter int MAX_SOURCE_WIDTH = DEF_MAX_SOURCE_WIDTH,
  localparam int WW = $clog2(MAX_SOURCE_WIDTH + 1),
  localparam int CW = $clog2(MAX_SOURCE_WIDTH),
  localparam int AW = $clog2(MAX_SOURCE_WIDTH / 2)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 accept,
  output ctl_t                 ctl,
  output logic [AW-1:0]        slot
);

  localparam int CMPW    = (WW > CFG_W) ? WW : CFG_W;
  localparam int RST_W   = (RST_SOURCE_WIDTH < MAX_SOURCE_WIDTH) ?
                           RST_SOURCE_WIDTH : MAX_SOURCE_WIDTH;

  logic [WW-1:0]    eff_w_r, eff_w_nxt;
  logic [HGT_W-1:0] eff_h_r, eff_h_nxt;
  logic [CW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [CMPW-1:0]  wval;
  logic             tiny_lvl, w_one, h_one, col_hit, row_hit;
  logic             col_end, row_end;
  logic [WW-1:0]    last_col;
  logic [HGT_W-1:0] last_row;

  assign wval = CMPW'(cfg_data);

  always_comb begin
    eff_w_nxt = eff_w_r;
    eff_h_nxt = eff_h_r;
    if (cfg_we && cfg_index == REG_SOURCE_WIDTH) begin
      if (cfg_data == '0) begin
        eff_w_nxt = WW'(1);
      end else if (wval > CMPW'(MAX_SOURCE_WIDTH)) begin
        eff_w_nxt = WW'(MAX_SOURCE_WIDTH);
      end else begin
        eff_w_nxt = wval[WW-1:0];
      end
    end
    if (cfg_we && cfg_index == REG_SOURCE_HEIGHT) begin
      if (cfg_data == '0) begin
        eff_h_nxt = HGT_W'(1);
      end else if (cfg_data > HGT_W'(MAX_SOURCE_HEIGHT)) begin
        eff_h_nxt = HGT_W'(MAX_SOURCE_HEIGHT);
      end else begin
        eff_h_nxt = cfg_data;
      end
    end
  end

  assign w_one    = (eff_w_r == WW'(1));
  assign h_one    = (eff_h_r == HGT_W'(1));
  assign tiny_lvl = (eff_w_r < WW'(4)) || (eff_h_r < HGT_W'(4));
  assign col_hit  = w_one || col_r[0];
  assign row_hit  = h_one || row_r[0];
  assign last_col = w_one ? '0 : {eff_w_r[WW-1:1], 1'b0} - WW'(1);
  assign last_row = h_one ? '0 : {eff_h_r[HGT_W-1:1], 1'b0} - HGT_W'(1);
  assign col_end  = (WW'(col_r) == eff_w_r - WW'(1));
  assign row_end  = (HGT_W'(row_r) == eff_h_r - HGT_W'(1));

  always_comb begin
    ctl.hold_left = !tiny_lvl && !col_r[0];
    ctl.line_wr   = !tiny_lvl && col_r[0] && !row_r[0];
    ctl.line_rd   = !tiny_lvl && col_r[0] && row_r[0];
    ctl.emit      = tiny_lvl ? (col_hit && row_hit) : (col_r[0] && row_r[0]);
    ctl.zero      = tiny_lvl;
    ctl.last      = (WW'(col_r) == last_col) && (HGT_W'(row_r) == last_row);
  end

  assign slot = col_r[AW:1];

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_we) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if (col_end) begin
        col_nxt = '0;
        row_nxt = row_end ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_w_r <= WW'(RST_W);
      eff_h_r <= HGT_W'(RST_SOURCE_HEIGHT);
      col_r   <= '0;
      row_r   <= '0;
    end else begin
      eff_w_r <= eff_w_nxt;
      eff_h_r <= eff_h_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
    end
  end

endmodule

### rtl/rbd_dp.sv
module rbd_dp import rbd_pkg::*; #(
  parameter int MAX_SOURCE_WIDTH = DEF_MAX_SOURCE_WIDTH,
  localparam int AW = $clog2(MAX_SOURCE_WIDTH / 2)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  pix_t          pixel,
  input  ctl_t          ctl,
  input  logic [AW-1:0] slot,
  output logic          in_free,
  rbd_mip_if.source     out_mip
);

  pix_t  held_r;
  line_t pair;
  line_t top;
  logic  s1_valid_r, s1_valid_nxt;
  line_t s1_pair_r;
  logic  s1_zero_r;
  logic  s1_last_r;
  logic  out_valid_r, out_valid_nxt;
  pix_t  out_pix_r;
  logic  out_last_r;
  logic  out_free, s1_move, s1_load;

  assign pair = pair_sum(held_r, pixel);

  rbd_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_SOURCE_WIDTH / 2)
  ) u_line (
    .clk   (clk),
    .we    (accept && ctl.line_wr),
    .waddr (slot),
    .wdata (pair),
    .re    (accept && ctl.line_rd),
    .raddr (slot),
    .rdata (top)
  );

  assign out_free = !out_valid_r || out_mip.ready;
  assign s1_move  = s1_valid_r && out_free;
  assign in_free  = !s1_valid_r || s1_move;
  assign s1_load  = accept && ctl.emit;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_load) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_mip.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && ctl.hold_left) begin
      held_r <= pixel;
    end
    if (s1_load) begin
      s1_pair_r <= pair;
      s1_zero_r <= ctl.zero;
      s1_last_r <= ctl.last;
    end
    if (s1_move) begin
      out_pix_r  <= s1_zero_r ? '0 : box_avg(top, s1_pair_r);
      out_last_r <= s1_last_r;
    end
  end

  assign out_mip.valid      = out_valid_r;
  assign out_mip.mip_pixel  = out_pix_r;
  assign out_mip.level_done = out_last_r;

endmodule

### rtl/rgba_box_downsample_2x2.sv
// 2x2 box-filter mipmap step for an RGBA8 raster stream. One source pixel is
// taken per clock while the holding stage has room; each output pixel
// (per-channel floor of the 2x2 sum / 4) goes from that one holding stage to a
// registered output stage, and the two let input keep flowing while a result
// waits. The even-row pair sums live in a line RAM of MAX_SOURCE_WIDTH/2 x 36
// bits (one write and one read port); it needs no clearing after reset.
// Writing source_width or source_height restarts the level; levels narrower or
// shorter than 4 pixels produce all-zero outputs. level_done marks the last
// output beat of each level.
module rgba_box_downsample_2x2 import rbd_pkg::*; #(
  parameter int MAX_SOURCE_WIDTH = DEF_MAX_SOURCE_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  rbd_src_if.sink              in_pix,
  rbd_mip_if.source            out_mip
);

  localparam int AW = $clog2(MAX_SOURCE_WIDTH / 2);

  ctl_t          ctl;
  logic [AW-1:0] slot;
  logic          in_free;
  logic          accept;

  assign in_pix.ready = in_free;
  assign accept       = in_pix.valid && in_free;

  rbd_seq #(
    .MAX_SOURCE_WIDTH (MAX_SOURCE_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .ctl       (ctl),
    .slot      (slot)
  );

  rbd_dp #(
    .MAX_SOURCE_WIDTH (MAX_SOURCE_WIDTH)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .pixel   (in_pix.source_pixel),
    .ctl     (ctl),
    .slot    (slot),
    .in_free (in_free),
    .out_mip (out_mip)
  );

endmodule

### rtl/rbd_chk.sv
module rbd_chk import rbd_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input pix_t out_mip_pixel,
  input logic out_level_done
);

  logic in_beat;
  assign in_beat = in_valid && in_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped before taken");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_mip_pixel) && $stable(out_level_done))
    else $error("result payload changed while stalled");

  a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_beat, 2))
    else $error("result appeared without an input beat two cycles earlier");

  a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while output stage is empty");

endmodule

bind rgba_box_downsample_2x2 rbd_chk u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_pix.valid),
  .in_ready       (in_pix.ready),
  .out_valid      (out_mip.valid),
  .out_ready      (out_mip.ready),
  .out_mip_pixel  (out_mip.mip_pixel),
  .out_level_done (out_mip.level_done)
);
